[rtl/cma_pkg.sv]
// shared types and constants of the calibrated moving average
package cma_pkg;

  localparam int OFFSET_W    = 17;
  localparam int SCALE_W     = 24;
  localparam int WIN_W       = 5;
  localparam int OUT_W       = 25;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int RAW_SHIFT   = 4;
  localparam int FRAC_SHIFT  = 16;
  localparam int SUM_W       = OUT_W + WIN_W;
  localparam int DIV_RADIX_B = 2;
  localparam int DIV_STEPS   = SUM_W / DIV_RADIX_B;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic signed [SCALE_W-1:0]  scale;
    logic        [WIN_W-1:0]    window;
  } cfg_t;

endpackage

[rtl/cma_front.sv]
// front end: accepts raw samples and applies offset and gain calibration
module cma_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                     raw_sample_i,
  input  logic signed [cma_pkg::OFFSET_W-1:0]        offset_i,
  input  logic signed [cma_pkg::SCALE_W-1:0]         scale_i,
  input  logic                                       q_full_i,
  output logic                                       q_push_o,
  output logic signed [cma_pkg::OUT_W-1:0]           q_data_o
);

  localparam int RAW_W = SAMPLE_BITS + cma_pkg::RAW_SHIFT;
  localparam int DW    = ((RAW_W > cma_pkg::OFFSET_W - 1) ? RAW_W : cma_pkg::OFFSET_W - 1) + 2;
  localparam int PM    = DW + cma_pkg::SCALE_W;
  localparam int SHW   = PM - cma_pkg::FRAC_SHIFT;
  localparam int HIW   = SHW - cma_pkg::OUT_W + 1;

  logic                 p1_v_q, p1_v_d, p2_v_q, p2_v_d;
  logic signed [DW-1:0] diff_q, diff_d;
  logic signed [PM-1:0] prod_q, prod_d;
  logic                 adv1, adv2, accept;
  logic signed [SHW-1:0] shifted;
  logic [HIW-1:0]       hi_bits;

  assign adv2       = p2_v_q & ~q_full_i;
  assign adv1       = p1_v_q & (~p2_v_q | adv2);
  assign in_ready_o = ~p1_v_q | adv1;
  assign accept     = in_valid_i & in_ready_o;

  assign p1_v_d = accept | (p1_v_q & ~adv1);
  assign p2_v_d = adv1 | (p2_v_q & ~adv2);

  // raw counts scaled to Q.4 minus the offset
  assign diff_d = DW'($signed({1'b0, raw_sample_i, {cma_pkg::RAW_SHIFT{1'b0}}}))
                  - DW'(offset_i);
  assign prod_d = PM'(diff_q) * PM'(scale_i);

  // arithmetic shift drops the gain fraction, then saturate to the output range
  assign shifted = prod_q[PM-1:cma_pkg::FRAC_SHIFT];
  assign hi_bits = shifted[SHW-1:cma_pkg::OUT_W-1];

  always_comb begin
    if ((hi_bits == '0) || (hi_bits == '1)) begin
      q_data_o = shifted[cma_pkg::OUT_W-1:0];
    end else if (shifted[SHW-1]) begin
      q_data_o = {1'b1, {(cma_pkg::OUT_W-1){1'b0}}};
    end else begin
      q_data_o = {1'b0, {(cma_pkg::OUT_W-1){1'b1}}};
    end
  end

  assign q_push_o = adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p1_v_q <= p1_v_d;
      p2_v_q <= p2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= diff_d;
    end
    if (adv1) begin
      prod_q <= prod_d;
    end
  end

endmodule

[rtl/cma_queue.sv]
// short queue of calibrated values between front and back
module cma_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic signed [cma_pkg::OUT_W-1:0]  data_i,
  output logic                              full_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [cma_pkg::OUT_W-1:0]  data_o
);

  localparam int PTR_W = (cma_pkg::QUEUE_DEPTH > 1) ? $clog2(cma_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cma_pkg::QUEUE_DEPTH + 1);

  logic signed [cma_pkg::OUT_W-1:0] slot_q [cma_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(cma_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(cma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(cma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/cma_back.sv]
// back end: sample ring, summing walk, radix-4 divider and result register
module cma_back #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cma_pkg::WIN_W-1:0]         window_i,
  input  logic                              win_clr_i,
  input  logic                              q_empty_i,
  input  logic signed [cma_pkg::OUT_W-1:0]  q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cma_pkg::OUT_W-1:0]  result_o
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int IW = (AW + 1 > cma_pkg::WIN_W) ? AW + 1 : cma_pkg::WIN_W;
  localparam int WW = cma_pkg::WIN_W;
  localparam int SW = cma_pkg::SUM_W;
  localparam int OW = cma_pkg::OUT_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WALK = 6'b000010,
    ST_PREP = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic [WW-1:0]  cnt_q, cnt_d;
  logic [IW-1:0]  issue_q, issue_d;
  logic           rd_v_q, rd_v_d;
  logic [cma_pkg::STEP_W-1:0] step_q, step_d;

  logic signed [SW-1:0] sum_q, sum_d;
  logic                 neg_q, neg_d;
  logic [SW-1:0]        dq_q, dq_d;
  logic [WW-1:0]        rem_q, rem_d;
  logic signed [OW-1:0] res_q, res_d;

  logic signed [OW-1:0] ring_mem [WINDOW_MAX];
  logic signed [OW-1:0] rdata_q;

  logic           ring_we, issue_go, multi;
  logic [IW-1:0]  pos_inc;
  logic [SW-1:0]  div_dq;
  logic [WW-1:0]  div_rem;
  logic [WW:0]    trial;

  assign multi    = (window_i > WW'(1));
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign ring_we  = q_pop_o && multi;
  assign issue_go = (state_q == ST_WALK) && (issue_q < IW'(cnt_q));
  assign pos_inc  = IW'(pos_q) + IW'(1);

  assign out_valid_o = (state_q == ST_OUT);
  assign result_o    = res_q;

  // two restoring division steps per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    div_dq  = dq_q;
    div_rem = rem_q;
    trial   = '0;
    for (int b = 0; b < cma_pkg::DIV_RADIX_B; b++) begin
      trial  = {div_rem, div_dq[SW-1]};
      div_dq = {div_dq[SW-2:0], 1'b0};
      if (trial >= {1'b0, cnt_q}) begin
        div_rem   = WW'(trial - {1'b0, cnt_q});
        div_dq[0] = 1'b1;
      end else begin
        div_rem = trial[WW-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    issue_d = issue_q;
    rd_v_d  = issue_go;
    step_d  = step_q;
    sum_d   = sum_q;
    neg_d   = neg_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (multi) begin
            pos_d   = (pos_inc == IW'(window_i)) ? '0 : pos_inc[AW-1:0];
            cnt_d   = (cnt_q < window_i) ? cnt_q + 1'b1 : cnt_q;
            issue_d = '0;
            sum_d   = '0;
            state_d = ST_WALK;
          end else begin
            res_d   = q_data_i;
            state_d = ST_OUT;
          end
        end
      end
      ST_WALK: begin
        if (issue_go) begin
          issue_d = issue_q + 1'b1;
        end
        if (rd_v_q) begin
          sum_d = sum_q + SW'(rdata_q);
          if (!issue_go) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        neg_d   = sum_q[SW-1];
        dq_d    = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dq_d   = div_dq;
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (step_q == cma_pkg::STEP_W'(cma_pkg::DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_d   = neg_q ? -OW'(dq_q) : OW'(dq_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // window change restarts the ring
    if (win_clr_i) begin
      pos_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
      issue_q <= '0;
      rd_v_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      issue_q <= issue_d;
      rd_v_q  <= rd_v_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    neg_q <= neg_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= q_data_i;
    end
    rdata_q <= ring_mem[issue_q[AW-1:0]];
  end

endmodule

[rtl/calibrated_moving_average.sv]
// top level of the calibrated moving average
// Usage: one raw converter sample per item on the input channel
// (in_valid_i/in_ready_o), one smoothed value per item on the output channel
// (out_valid_o/out_ready_i). Offset, scale and window are set through the
// write port (cfg_we_i, cfg_idx_i, cfg_data_i) while no item is in flight;
// a window write clamps to 1..WINDOW_MAX (at most 31) and restarts the average.
// The front end calibrates in two stages (subtract, then multiply) and
// feeds a two-entry queue; the back end runs one item at a time.
// Window of one: the back end passes the queue head straight to the result
// register and takes no new item until that result is taken. Larger windows:
// the back end sums the filled part of the ring (summing walk of one ring read
// per cycle), then runs 15 radix-4 divider steps before the result is shown.
// Reset clears offset to 0, scale to 1.0, window to 1 and empties the
// ring, queue and pipeline; ring contents stay unset until written.
// A stalled receiver holds the result register; the queue and the front
// end keep taking items until they fill, then in_ready_o drops.
module calibrated_moving_average #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [cma_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [cma_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                 raw_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cma_pkg::OUT_W-1:0]       smoothed_value_o
);

  localparam int WIN_CAP = (WINDOW_MAX > (2 ** cma_pkg::WIN_W) - 1) ?
                           (2 ** cma_pkg::WIN_W) - 1 : WINDOW_MAX;

  cma_pkg::cfg_t cfg_q, cfg_d;
  logic [cma_pkg::WIN_W-1:0] win_raw, win_clamped;
  logic win_clr;

  logic q_push, q_full, q_pop, q_empty;
  logic signed [cma_pkg::OUT_W-1:0] q_wdata, q_rdata;

  assign win_raw = cfg_data_i[cma_pkg::WIN_W-1:0];

  always_comb begin
    if (win_raw == '0) begin
      win_clamped = cma_pkg::WIN_W'(1);
    end else if (int'(win_raw) > WIN_CAP) begin
      win_clamped = cma_pkg::WIN_W'(WIN_CAP);
    end else begin
      win_clamped = win_raw;
    end
  end

  always_comb begin
    cfg_d   = cfg_q;
    win_clr = 1'b0;
    if (cfg_we_i) begin
      unique case (cma_pkg::cfg_idx_e'(cfg_idx_i))
        cma_pkg::CFG_OFFSET: cfg_d.offset = cfg_data_i[cma_pkg::OFFSET_W-1:0];
        cma_pkg::CFG_SCALE:  cfg_d.scale  = cfg_data_i[cma_pkg::SCALE_W-1:0];
        cma_pkg::CFG_WINDOW: begin
          cfg_d.window = win_clamped;
          win_clr      = 1'b1;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset <= '0;
      cfg_q.scale  <= cma_pkg::SCALE_W'(65536);
      cfg_q.window <= cma_pkg::WIN_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cma_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_sample_i(raw_sample_i),
    .offset_i    (cfg_q.offset),
    .scale_i     (cfg_q.scale),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  cma_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  cma_back #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .window_i   (cfg_q.window),
    .win_clr_i  (win_clr),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (smoothed_value_o)
  );

  // front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  // back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // input side only closes after taking an item
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("in_ready_o dropped without an accepted item");

endmodule

[sim/calibrated_moving_average_tb.sv]
// testbench of the calibrated moving average: directed and random items against a predictor
module calibrated_moving_average_tb;

  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int SHOW_LIMIT  = 10;
  localparam logic [cma_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint OUT_HI = (longint'(1) <<< (cma_pkg::OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (cma_pkg::OUT_W - 1));

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            cfg_we_i     = 1'b0;
  logic [cma_pkg::CFG_IDX_W-1:0]   cfg_idx_i    = '0;
  logic [cma_pkg::CFG_DATA_W-1:0]  cfg_data_i   = '0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_ready_o;
  logic [SAMPLE_BITS-1:0]          raw_sample_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i  = 1'b0;
  logic signed [cma_pkg::OUT_W-1:0] smoothed_value_o;

  calibrated_moving_average #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .smoothed_value_o(smoothed_value_o)
  );

  // predictor state, mirrors the block's registers and ring
  logic signed [cma_pkg::OFFSET_W-1:0] cal_offset = '0;
  logic signed [cma_pkg::SCALE_W-1:0]  cal_scale  = 24'sh010000;
  logic [cma_pkg::WIN_W-1:0]           avg_window = 5'd1;
  logic [3:0]                          ring_pos   = '0;
  logic [cma_pkg::WIN_W-1:0]           ring_fill  = '0;
  logic signed [cma_pkg::OUT_W-1:0]    ring_vals [WINDOW_MAX];

  logic signed [cma_pkg::OUT_W-1:0] smoothed_due [$];
  logic signed [cma_pkg::OUT_W-1:0] want;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  bit steady         = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [cma_pkg::OUT_W-1:0] calibrate(
    input logic [SAMPLE_BITS-1:0] raw
  );
    longint prod;
    prod = (longint'(raw) * 16 - longint'(cal_offset)) * longint'(cal_scale);
    prod = prod >>> cma_pkg::FRAC_SHIFT;
    if (prod > OUT_HI) prod = OUT_HI;
    if (prod < OUT_LO) prod = OUT_LO;
    return cma_pkg::OUT_W'(prod);
  endfunction

  function automatic logic signed [cma_pkg::OUT_W-1:0] predict_smoothed(
    input logic [SAMPLE_BITS-1:0] raw
  );
    logic signed [cma_pkg::OUT_W-1:0] cal;
    longint total;
    cal = calibrate(raw);
    if (avg_window <= 1) return cal;
    ring_vals[ring_pos] = cal;
    ring_pos = 4'((int'(ring_pos) + 1) % int'(avg_window));
    if (ring_fill < avg_window) ring_fill = ring_fill + 1'b1;
    total = 0;
    for (int i = 0; i < int'(ring_fill); i++) total += longint'(ring_vals[i]);
    // signed division truncates toward zero
    return cma_pkg::OUT_W'(total / longint'(ring_fill));
  endfunction

  task automatic flag_error(input string what,
                            input logic signed [cma_pkg::OUT_W-1:0] exp_v,
                            input logic signed [cma_pkg::OUT_W-1:0] got_v);
    if (mismatch_count < SHOW_LIMIT)
      $display("%s: expected %0d, got %0d", what, exp_v, got_v);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (smoothed_due.size() == 0) begin
        flag_error("result with no item pending", 'x, smoothed_value_o);
      end else begin
        want = smoothed_due.pop_front();
        if (smoothed_value_o !== want) flag_error("smoothed_value", want, smoothed_value_o);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("calibrated_moving_average_tb: done, errors");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
    if (!steady) begin
      while ($urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    smoothed_due.push_back(predict_smoothed(raw));
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (smoothed_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cma_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cma_pkg::CFG_DATA_W-1:0] data);
    logic [cma_pkg::WIN_W-1:0] w;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      cma_pkg::CFG_OFFSET: cal_offset = data[cma_pkg::OFFSET_W-1:0];
      cma_pkg::CFG_SCALE:  cal_scale  = data[cma_pkg::SCALE_W-1:0];
      cma_pkg::CFG_WINDOW: begin
        w = data[cma_pkg::WIN_W-1:0];
        if (w == 0) w = 1;
        else if (w > WINDOW_MAX) w = WINDOW_MAX;
        avg_window = w;
        ring_pos   = '0;
        ring_fill  = '0;
      end
      default: ;
    endcase
  endtask

  // reset values: unit gain, no offset, window of one
  task automatic test_reset_passthrough();
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'd1);
    drain();
  endtask

  task automatic test_calibration_extremes();
    write_reg(cma_pkg::CFG_OFFSET, 24'h00FFFF);
    write_reg(cma_pkg::CFG_SCALE, 24'h7FFFFF);
    send_sample(12'd0);
    send_sample(12'hFFF);
    drain();
    // upper data bits above the offset width are dropped
    write_reg(cma_pkg::CFG_OFFSET, 24'hFF0000 | 24'h010000);
    write_reg(cma_pkg::CFG_SCALE, 24'h800000);
    send_sample(12'd0);
    send_sample(12'hFFF);
    drain();
    write_reg(cma_pkg::CFG_SCALE, 24'h000000);
    send_sample(12'h7A5);
    drain();
    write_reg(CFG_SPARE, 24'($urandom));
    send_sample(12'h123);
    drain();
  endtask

  task automatic test_window_clamp_and_clear();
    write_reg(cma_pkg::CFG_OFFSET, 24'd0);
    write_reg(cma_pkg::CFG_SCALE, 24'hFF0000);
    // zero clamps up to one
    write_reg(cma_pkg::CFG_WINDOW, 24'd0);
    send_sample(12'hFFF);
    drain();
    // 31 clamps down to the largest window
    write_reg(cma_pkg::CFG_WINDOW, 24'hFFFFFF);
    send_sample(12'd3);
    send_sample(12'd5);
    send_sample(12'hFFF);
    drain();
    // negative sums truncate toward zero
    write_reg(cma_pkg::CFG_WINDOW, 24'd3);
    send_sample(12'd1);
    send_sample(12'd2);
    send_sample(12'd4);
    drain();
    // same window again still restarts the average
    write_reg(cma_pkg::CFG_WINDOW, 24'd3);
    send_sample(12'd7);
    drain();
  endtask

  task automatic test_random_phases(input int total);
    int sent;
    int phase;
    int burst;
    logic [cma_pkg::CFG_DATA_W-1:0] data;
    logic [SAMPLE_BITS-1:0] raw;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      drain();
      data = 24'($urandom);
      case ($urandom_range(4))
        0: data[cma_pkg::OFFSET_W-1:0] = 17'h0FFFF;
        1: data[cma_pkg::OFFSET_W-1:0] = 17'h10000;
        2: data[cma_pkg::OFFSET_W-1:0] = '0;
        default: ;
      endcase
      write_reg(cma_pkg::CFG_OFFSET, data);
      data = 24'($urandom);
      case ($urandom_range(5))
        0: data = 24'h7FFFFF;
        1: data = 24'h800000;
        2: data = 24'h010000;
        3: data = 24'(int'($urandom_range(0, 20'hFFFFF)) - 20'h80000);
        default: ;
      endcase
      write_reg(cma_pkg::CFG_SCALE, data);
      data = 24'($urandom);
      case ($urandom_range(3))
        0: data[cma_pkg::WIN_W-1:0] = 5'd16;
        1: data[cma_pkg::WIN_W-1:0] = 5'd1;
        default: data[cma_pkg::WIN_W-1:0] = 5'($urandom_range(0, 31));
      endcase
      if (phase == 1) data[cma_pkg::WIN_W-1:0] = 5'd16;
      write_reg(cma_pkg::CFG_WINDOW, data);
      if ($urandom_range(5) == 0) write_reg(CFG_SPARE, 24'($urandom));
      burst  = $urandom_range(20, 60);
      steady = (phase == 1) || ($urandom_range(5) == 0);
      for (int k = 0; k < burst && sent < total; k++) begin
        if ($urandom_range(60) == 0) drain();
        case ($urandom_range(7))
          0: raw = '0;
          1: raw = '1;
          2: raw = SAMPLE_BITS'($urandom_range(0, 15));
          default: raw = SAMPLE_BITS'($urandom);
        endcase
        send_sample(raw);
        sent++;
      end
      steady = 1'b0;
      phase++;
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_passthrough();
    test_calibration_extremes();
    test_window_clamp_and_clear();
    test_random_phases(950);
    repeat (60) @(posedge clk_i);
    if (smoothed_due.size() != 0) mismatch_count += smoothed_due.size();
    if (mismatch_count == 0)
      $display("calibrated_moving_average_tb: done, clean");
    else
      $display("calibrated_moving_average_tb: done, errors");
    $finish;
  end

endmodule
